// ===== sv/mcs_pkg.sv =====
// Package for the MIDI chord stepper: payload structs, controller state,
// command and status bundles, and fixed constants. No dependencies.
package mcs_pkg;

    // Input item and result payloads
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  status;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic        new_chord;
        logic [15:0] sample_pos;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_status;
        logic [6:0]  out_data1;
        logic [6:0]  out_data2;
        logic [15:0] out_pos;
        logic        last;
    } result_t;

    // Operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_MSG    = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W          = 1;
    localparam logic [0:0] CFG_RELEASE_MODE   = 1'd0;
    localparam logic [0:0] CFG_VEL_SENSITIVE  = 1'd1;

    // MIDI constants
    localparam logic [7:0] ST_NOTE_ON      = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF     = 8'h80;
    localparam logic [6:0] FIXED_VELOCITY  = 7'd100;

    // Note set scan: 128 notes viewed as 8 chunks of 16
    localparam int NOTE_COUNT = 128;
    localparam int CHUNK_W    = 16;
    localparam int NCHUNK     = NOTE_COUNT / CHUNK_W;
    localparam int CHUNK_SEL_W = $clog2(NCHUNK);
    localparam int CHUNK_IDX_W = $clog2(CHUNK_W);

    // Result cap per input item
    localparam int         RESULT_CAP = 16;
    localparam int         NRES_W     = $clog2(RESULT_CAP + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REL,
        ST_PLAY_SIZE,
        ST_PLAY_RD,
        ST_PLAY_EM,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_item;
        logic exec_clear;
        logic exec_append;
        logic exec_pass;
        logic set_held;
        logic clr_held;
        logic start_play;
        logic start_rel;
        logic rel_emit;
        logic rel_adv;
        logic play_emit;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       is_note_on;
        logic       is_note_off;
        logic       was_empty;
        logic       held_empty_after;
        logic       can_play;
        logic       release_mode;
        logic       rel_hit;
        logic       rel_last_chunk;
        logic       n_full;
        logic       play_done;
        logic       can_push;
        logic       pend_valid;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== sv/mcs_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
module mcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mcs_ctrl.sv =====
// Controller state machine of the chord stepper.
// Depends on mcs_pkg; drives commands into mcs_dp and reads its status.
module mcs_ctrl
    import mcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   play_after_reg, play_after_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            play_after_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            play_after_reg <= play_after_next;
        end
    end

    // Next state
    always_comb begin
        state_next      = state_reg;
        play_after_next = play_after_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                case (stat.op)
                    OP_MSG: begin
                        if (stat.count_zero || !(stat.is_note_on || stat.is_note_off)) begin
                            state_next = ST_FINISH;
                        end else if (stat.is_note_on) begin
                            if (stat.was_empty && stat.can_play) begin
                                play_after_next = 1'b1;
                                state_next = stat.release_mode ? ST_REL : ST_PLAY_SIZE;
                            end
                        end else if (stat.held_empty_after && !stat.release_mode) begin
                            play_after_next = 1'b0;
                            state_next      = ST_REL;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_REL: begin
                if (stat.n_full || (!stat.rel_hit && stat.rel_last_chunk)) begin
                    state_next = play_after_reg ? ST_PLAY_SIZE : ST_FINISH;
                end
            end
            ST_PLAY_SIZE: state_next = ST_PLAY_RD;
            ST_PLAY_RD: begin
                state_next = (stat.play_done || stat.n_full) ? ST_FINISH : ST_PLAY_EM;
            end
            ST_PLAY_EM: begin
                if (stat.can_push) begin
                    state_next = ST_PLAY_RD;
                end
            end
            ST_FINISH: begin
                if (!stat.pend_valid || stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_EXEC: begin
                case (stat.op)
                    OP_CLEAR:  cmd.exec_clear  = 1'b1;
                    OP_APPEND: cmd.exec_append = 1'b1;
                    OP_MSG: begin
                        if (stat.count_zero || !(stat.is_note_on || stat.is_note_off)) begin
                            cmd.exec_pass = 1'b1;
                        end else if (stat.is_note_on) begin
                            cmd.set_held = 1'b1;
                            if (stat.was_empty && stat.can_play) begin
                                cmd.start_play = 1'b1;
                                cmd.start_rel  = stat.release_mode;
                            end
                        end else begin
                            cmd.clr_held  = 1'b1;
                            cmd.start_rel = stat.held_empty_after && !stat.release_mode;
                        end
                    end
                    default: cmd = '0;
                endcase
            end
            ST_REL: begin
                if (!stat.n_full) begin
                    if (stat.rel_hit) begin
                        cmd.rel_emit = stat.can_push;
                    end else if (!stat.rel_last_chunk) begin
                        cmd.rel_adv = 1'b1;
                    end
                end
            end
            ST_PLAY_EM: cmd.play_emit = stat.can_push;
            ST_FINISH:  cmd.finish    = stat.pend_valid && stat.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

// ===== sv/mcs_dp.sv =====
// Datapath of the chord stepper: item latch, chord list stores, key and
// note sets, release scan, pending and output result registers.
// Depends on mcs_pkg and mcs_ram; commanded by mcs_ctrl.
module mcs_dp
    import mcs_pkg::*;
#(
    parameter int MAX_CHORDS          = 256,
    parameter int MAX_NOTES_PER_CHORD = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  item_t                s_item,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_wdata,
    output logic                 m_valid,
    input  logic                 m_ready,
    output result_t              m_result,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           stat
);

    localparam int CH_W   = (MAX_CHORDS > 1) ? $clog2(MAX_CHORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHORDS + 1);
    localparam int SIZE_W = $clog2(MAX_NOTES_PER_CHORD + 1);
    localparam int PDEPTH = MAX_CHORDS * MAX_NOTES_PER_CHORD;
    localparam int PA_W   = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

    function automatic logic [CHUNK_IDX_W-1:0] lowest_set(input logic [CHUNK_W-1:0] v);
        logic [CHUNK_IDX_W-1:0] idx;
        idx = '0;
        for (int k = CHUNK_W - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = CHUNK_IDX_W'(k);
            end
        end
        return idx;
    endfunction

    item_t                  item_reg;
    logic                   release_mode_reg, vel_sens_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       next_reg, next_next;
    logic [CH_W-1:0]        last_idx_reg, last_idx_next;
    logic [PA_W-1:0]        last_base_reg, last_base_next;
    logic [PA_W-1:0]        next_base_reg, next_base_next;
    logic [SIZE_W-1:0]      cur_size_reg, cur_size_next;
    logic [CH_W-1:0]        play_idx_reg, play_idx_next;
    logic [PA_W-1:0]        play_base_reg, play_base_next;
    logic [SIZE_W-1:0]      i_reg, i_next;
    logic [NOTE_COUNT-1:0]  held_reg, held_next;
    logic [NOTE_COUNT-1:0]  sound_reg, sound_next;
    logic [CHUNK_SEL_W-1:0] chunk_reg, chunk_next;
    logic [NRES_W-1:0]      n_reg, n_next;
    logic                   pend_valid_reg, pend_valid_next;
    result_t                pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    logic              p_we, s_we;
    logic [PA_W-1:0]   p_waddr;
    logic [CH_W-1:0]   s_waddr;
    logic [SIZE_W-1:0] s_wdata;
    logic [6:0]        pitch_rdata;
    logic [SIZE_W-1:0] size_rdata;

    logic [CHUNK_W-1:0]     chunk_bits;
    logic [CHUNK_IDX_W-1:0] rel_idx;
    logic                   is_on, is_off, push, out_free, out_load;
    logic [NOTE_COUNT-1:0]  key_mask;

    mcs_ram #(.WIDTH(7), .DEPTH(PDEPTH)) u_pitch_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (item_reg.data1),
        .raddr (PA_W'(play_base_reg + PA_W'(i_reg))),
        .rdata (pitch_rdata)
    );

    mcs_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_CHORDS)) u_size_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (play_idx_reg),
        .rdata (size_rdata)
    );

    // Message classification
    always_comb begin
        is_on  = (item_reg.status inside {[8'h90:8'h9F]}) && (item_reg.data2 != 7'd0);
        is_off = (item_reg.status inside {[8'h80:8'h8F]}) ||
                 ((item_reg.status inside {[8'h90:8'h9F]}) && (item_reg.data2 == 7'd0));
    end

    assign key_mask   = NOTE_COUNT'(1) << item_reg.data1;
    assign chunk_bits = sound_reg[{chunk_reg, {CHUNK_IDX_W{1'b0}}} +: CHUNK_W];
    assign rel_idx    = lowest_set(chunk_bits);
    assign out_free   = !out_valid_reg || m_ready;
    assign push       = cmd.exec_pass || cmd.rel_emit || cmd.play_emit;
    assign out_load   = pend_valid_reg && (push || cmd.finish);

    always_comb begin
        stat.op               = item_reg.op;
        stat.count_zero       = (count_reg == '0);
        stat.is_note_on       = is_on;
        stat.is_note_off      = is_off;
        stat.was_empty        = (held_reg == '0);
        stat.held_empty_after = ((held_reg & ~key_mask) == '0);
        stat.can_play         = (next_reg < count_reg);
        stat.release_mode     = release_mode_reg;
        stat.rel_hit          = (chunk_bits != '0);
        stat.rel_last_chunk   = (chunk_reg == CHUNK_SEL_W'(NCHUNK - 1));
        stat.n_full           = (n_reg == NRES_W'(RESULT_CAP));
        stat.play_done        = (i_reg >= size_rdata);
        stat.can_push         = !pend_valid_reg || out_free;
        stat.pend_valid       = pend_valid_reg;
        stat.out_free         = out_free;
    end

    // Chord list bookkeeping and append writes
    always_comb begin
        count_next     = count_reg;
        next_next      = next_reg;
        last_idx_next  = last_idx_reg;
        last_base_next = last_base_reg;
        next_base_next = next_base_reg;
        cur_size_next  = cur_size_reg;
        play_idx_next  = play_idx_reg;
        play_base_next = play_base_reg;
        i_next         = i_reg;
        p_we           = 1'b0;
        s_we           = 1'b0;
        p_waddr        = last_base_reg;
        s_waddr        = last_idx_reg;
        s_wdata        = cur_size_reg;
        if (cmd.exec_clear) begin
            count_next     = '0;
            next_next      = '0;
            next_base_next = '0;
        end
        if (cmd.exec_append) begin
            if (item_reg.new_chord || count_reg == '0) begin
                if (count_reg < CNT_W'(MAX_CHORDS)) begin
                    last_idx_next  = count_reg[CH_W-1:0];
                    last_base_next = (count_reg == '0) ? '0 :
                                     PA_W'(last_base_reg + PA_W'(MAX_NOTES_PER_CHORD));
                    count_next     = CNT_W'(count_reg + CNT_W'(1));
                    cur_size_next  = SIZE_W'(1);
                    p_we           = 1'b1;
                    p_waddr        = last_base_next;
                    s_we           = 1'b1;
                    s_waddr        = last_idx_next;
                    s_wdata        = SIZE_W'(1);
                end
            end else if (cur_size_reg < SIZE_W'(MAX_NOTES_PER_CHORD)) begin
                cur_size_next = SIZE_W'(cur_size_reg + SIZE_W'(1));
                p_we          = 1'b1;
                p_waddr       = PA_W'(last_base_reg + PA_W'(cur_size_reg));
                s_we          = 1'b1;
                s_wdata       = cur_size_next;
            end
        end
        if (cmd.start_play) begin
            play_idx_next  = next_reg[CH_W-1:0];
            play_base_next = next_base_reg;
            next_next      = CNT_W'(next_reg + CNT_W'(1));
            next_base_next = PA_W'(next_base_reg + PA_W'(MAX_NOTES_PER_CHORD));
            i_next         = '0;
        end
        if (cmd.play_emit) begin
            i_next = SIZE_W'(i_reg + SIZE_W'(1));
        end
    end

    // Key and note sets, scan, result candidates
    always_comb begin
        held_next       = held_reg;
        sound_next      = sound_reg;
        chunk_next      = chunk_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        if (cmd.load_item) begin
            n_next = '0;
        end
        if (cmd.set_held) begin
            held_next = held_reg | key_mask;
        end
        if (cmd.clr_held) begin
            held_next = held_reg & ~key_mask;
        end
        if (cmd.start_rel) begin
            chunk_next = '0;
        end
        if (cmd.rel_adv) begin
            chunk_next = CHUNK_SEL_W'(chunk_reg + CHUNK_SEL_W'(1));
        end
        if (cmd.exec_pass) begin
            pend_next = '{item_reg.status, item_reg.data1, item_reg.data2,
                          item_reg.sample_pos, 1'b0};
        end
        if (cmd.rel_emit) begin
            sound_next[{chunk_reg, rel_idx}] = 1'b0;
            pend_next = '{ST_NOTE_OFF, {chunk_reg, rel_idx}, 7'd0,
                          item_reg.sample_pos, 1'b0};
        end
        if (cmd.play_emit) begin
            sound_next[pitch_rdata] = 1'b1;
            pend_next = '{ST_NOTE_ON, pitch_rdata,
                          vel_sens_reg ? item_reg.data2 : FIXED_VELOCITY,
                          item_reg.sample_pos, 1'b0};
        end
        if (push) begin
            pend_valid_next = 1'b1;
            n_next          = NRES_W'(n_reg + NRES_W'(1));
        end
        if (cmd.finish) begin
            pend_valid_next = 1'b0;
        end
        // Older pending result moves on; last is known only at finish
        if (out_load) begin
            out_valid_next = 1'b1;
            out_next       = pend_reg;
            out_next.last  = cmd.finish;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            release_mode_reg <= 1'b0;
            vel_sens_reg     <= 1'b0;
            count_reg        <= '0;
            next_reg         <= '0;
            next_base_reg    <= '0;
            cur_size_reg     <= '0;
            held_reg         <= '0;
            sound_reg        <= '0;
            n_reg            <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == CFG_RELEASE_MODE) begin
                release_mode_reg <= cfg_wdata;
            end
            if (cfg_valid && cfg_index == CFG_VEL_SENSITIVE) begin
                vel_sens_reg <= cfg_wdata;
            end
            count_reg      <= count_next;
            next_reg       <= next_next;
            next_base_reg  <= next_base_next;
            cur_size_reg   <= cur_size_next;
            held_reg       <= held_next;
            sound_reg      <= sound_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_item;
        end
        last_idx_reg  <= last_idx_next;
        last_base_reg <= last_base_next;
        play_idx_reg  <= play_idx_next;
        play_base_reg <= play_base_next;
        i_reg         <= i_next;
        chunk_reg     <= chunk_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    a_n_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NRES_W'(RESULT_CAP))
        else $error("result count above cap");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("output register overwritten while stalled");

    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (out_valid_reg && out_reg.last))
        else $error("final result not marked last");

    a_next_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        next_reg <= count_reg)
        else $error("chord pointer beyond list");

endmodule

// ===== sv/midi_chord_stepper.sv =====
// Top level of the MIDI chord stepper: controller plus datapath.
// Depends on mcs_pkg, mcs_ctrl, mcs_dp (which holds two mcs_ram stores).
//
//  channel   direction  ports                            moves per transfer
//  -------   ---------  -------------------------------  --------------------------
//  input     in         s_valid s_ready s_item           one op / MIDI message
//  result    out        m_valid m_ready m_result         one MIDI result, last flag
//  config    in         cfg_valid cfg_ready cfg_index    one register write
//                       cfg_wdata
//
// Steps: clear, append and non-sounding note messages pass through ST_EXEC
// to ST_IDLE; a passed message goes on through ST_FINISH. A release walks
// the 128-note set in chunks of 16, one note-off per sounding note; a chord
// reads its size, then per note a registered pitch store read and an emit,
// then closes in ST_FINISH.
// Reset is synchronous and active low; chord stores need no clearing pass.
// A stalled result side holds the sequencer at the next emit; the next
// item is accepted while the final result still waits in the output register.
module midi_chord_stepper
    import mcs_pkg::*;
#(
    parameter int MAX_CHORDS          = 256,
    parameter int MAX_NOTES_PER_CHORD = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  item_t                s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output result_t              m_result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_wdata
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // Writes must come only while idle; the block does not enforce it and always takes them
    assign cfg_ready = 1'b1;

    mcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mcs_dp #(
        .MAX_CHORDS          (MAX_CHORDS),
        .MAX_NOTES_PER_CHORD (MAX_NOTES_PER_CHORD)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
